FILE: rtl/cfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the checksum frame serializer.
// ----------------------------------------------------------------------------
package cfs_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam int HEADER_BYTES = 5;
    localparam int SUM_BYTES    = 4;
    localparam int STEP_W       = 4;
    localparam int MAX_STEP     = HEADER_BYTES + SUM_BYTES - 1;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic {
        ITEM_START = 1'b0,
        ITEM_DATA  = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] device_id;
        logic [7:0] payload_length;
        logic [7:0] command_code;
        logic [7:0] data_byte;
    } cfs_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } cfs_result_t;

    typedef enum logic {
        JOB_HEADER = 1'b0,
        JOB_DATA   = 1'b1
    } job_kind_t;

    // One queued unit of work: a header or one payload byte, optionally
    // followed by the four checksum bytes.
    typedef struct packed {
        job_kind_t   kind;
        logic        with_sum;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [31:0] sum;
    } cfs_job_t;

endpackage

FILE: rtl/cfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_front
// Accepts items, tracks the open frame and the running sum, and posts jobs.
// ----------------------------------------------------------------------------
module cfs_front
    import cfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  cfs_item_t item,
    input  logic      q_full,
    output logic      q_write,
    output cfs_job_t  q_job
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [7:0]  bytes_left_reg;
    logic [7:0]  bytes_left_next;
    logic [31:0] running_sum_reg;
    logic [31:0] running_sum_next;

    logic        accept;
    logic        is_start;
    logic [7:0]  left_dec;
    logic [31:0] sum_new;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_start = (item_kind_t'(item.cmd) == ITEM_START);
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb
    begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        q_write          = 1'b0;
        q_job            = '0;
        sum_new          = '0;
        if (is_start)
        begin
            sum_new = 32'(SYNC_FIRST) + 32'(SYNC_SECOND) + 32'(item.device_id)
                    + 32'(item.payload_length) + 32'(item.command_code);
            q_job.kind     = JOB_HEADER;
            q_job.with_sum = (item.payload_length == 8'd0);
            q_job.b0       = item.device_id;
            q_job.b1       = item.payload_length;
            q_job.b2       = item.command_code;
            q_job.sum      = sum_new;
            if (accept)
            begin
                q_write          = 1'b1;
                running_sum_next = sum_new;
                frame_open_next  = (item.payload_length != 8'd0);
                bytes_left_next  = item.payload_length;
            end
        end
        else
        begin
            sum_new = running_sum_reg + 32'(item.data_byte);
            q_job.kind     = JOB_DATA;
            q_job.with_sum = (left_dec == 8'd0);
            q_job.b0       = item.data_byte;
            q_job.sum      = sum_new;
            if (accept && frame_open_reg)
            begin
                q_write          = 1'b1;
                running_sum_next = sum_new;
                frame_open_next  = (left_dec != 8'd0);
                bytes_left_next  = left_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
        end
        else
        begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

FILE: rtl/cfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_queue
// Short job queue between the front and the back; head shown combinationally.
// ----------------------------------------------------------------------------
module cfs_queue
    import cfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  cfs_job_t wr_job,
    output logic     q_full,
    input  logic     rd,
    output logic     q_valid,
    output cfs_job_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cfs_job_t         slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/cfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_back
// Expands the head job into frame bytes, one per cycle into the result
// register when it is empty or being popped; a held result stalls it.
// ----------------------------------------------------------------------------
module cfs_back
    import cfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cfs_job_t    head,
    output logic        q_read,
    input  logic        pop,
    output logic        empty,
    output cfs_result_t result
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    cfs_result_t       result_reg;

    logic              advance;
    logic              last;
    logic              in_header;
    logic [STEP_W-1:0] base;
    logic [STEP_W-1:0] count;
    logic [1:0]        sum_idx;
    logic [7:0]        byte_sel;

    assign base    = (head.kind == JOB_HEADER) ? STEP_W'(HEADER_BYTES) : STEP_W'(1);
    assign count   = base + (head.with_sum ? STEP_W'(SUM_BYTES) : '0);
    assign last    = (step_reg == count - 1'b1);
    assign advance = q_valid && (!out_valid_reg || pop);
    assign q_read  = advance && last;
    assign sum_idx = 2'(step_reg - base);
    assign in_header = (head.kind == JOB_HEADER) && (step_reg < STEP_W'(HEADER_BYTES));

    always_comb
    begin
        byte_sel = '0;
        if (in_header)
        begin
            case (step_reg)
                STEP_W'(0): byte_sel = SYNC_FIRST;
                STEP_W'(1): byte_sel = SYNC_SECOND;
                STEP_W'(2): byte_sel = head.b0;
                STEP_W'(3): byte_sel = head.b1;
                default:    byte_sel = head.b2;
            endcase
        end
        else if ((head.kind == JOB_DATA) && (step_reg == '0))
        begin
            byte_sel = head.b0;
        end
        else
        begin
            case (sum_idx)
                2'd0:    byte_sel = head.sum[31:24];
                2'd1:    byte_sel = head.sum[23:16];
                2'd2:    byte_sel = head.sum[15:8];
                default: byte_sel = head.sum[7:0];
            endcase
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            step_next = last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.out_byte  <= byte_sel;
            result_reg.frame_end <= last && head.with_sum;
            result_reg.run_last  <= last;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(MAX_STEP))
        else $error("step counter out of range");

    a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> q_valid)
        else $error("job left the queue part way through");

    a_read_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        q_read |-> (q_valid && advance))
        else $error("queue read without a transfer into the result register");

    a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled");

endmodule

FILE: rtl/checksum_frame_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_serializer
// Turns start and payload items into framed byte packets with a 32-bit
// additive checksum.
//
// Input channel: item with push/full; transfer when push is high and full low.
// A start item yields 0x55, 0xAA, id, length, command (plus the four checksum
// bytes, most significant first, when the length is zero). A payload item of
// an open frame yields its byte, plus the checksum after the last one. A
// payload item with no open frame is taken and gives nothing.
// Result channel: result with empty/pop; the oldest byte is shown while empty
// is low and is transferred when pop is high.
// An item's job is written into the queue; its first byte is then loaded
// into the result register and shown, unless a held result stalls it.
// The expander gives one result byte per cycle while pop keeps up; a payload
// stream sustains one item per cycle, and a header yields five or nine bytes.
// A job queue of QUEUE_DEPTH entries separates intake from expansion; full
// rises when it fills, which happens when the receiver stalls on pop or when
// headers and checksums arrive faster than their bytes drain.
// Reset clears the open frame, the checksum and the queue, and empties the
// result register.
// ----------------------------------------------------------------------------
module checksum_frame_serializer
    import cfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  cfs_item_t   item,
    output logic        empty,
    input  logic        pop,
    output cfs_result_t result
);

    logic     q_full;
    logic     q_write;
    cfs_job_t q_job;
    logic     q_read;
    logic     q_valid;
    cfs_job_t head;

    cfs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_full  (q_full),
        .q_write (q_write),
        .q_job   (q_job)
    );

    cfs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wr_job  (q_job),
        .q_full  (q_full),
        .rd      (q_read),
        .q_valid (q_valid),
        .head    (head)
    );

    cfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .q_read  (q_read),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
